/* hdl/trial_division_prime_check_assert.svh */
// Assertion macros for the prime check block.
// Assertions sample on clk_i and hold off while rst_ni is low.
`ifndef TRIAL_DIVISION_PRIME_CHECK_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_CHECK_ASSERT_SVH

`ifndef SYNTHESIS

`define TDPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tdpc assertion failed");

`define TDPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdpc assertion failed");

`else

`define TDPC_ASSERT(lbl, prop)
`define TDPC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/tdpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tdpc_pkg;

  localparam int VALUE_BITS = 31;
  // Divisor width: holds floor(sqrt(2^VALUE_BITS)) + 1.
  localparam int DIV_W = (VALUE_BITS + 1) / 2 + 1;
  // Running square of the divisor, one bit beyond the candidate.
  localparam int SQ_W = VALUE_BITS + 1;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(2);
  localparam logic [SQ_W-1:0] FIRST_SQUARE = SQ_W'(4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIV_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } div_rsp_t;

  typedef struct packed {
    logic                  fin;
    logic                  prime;
    logic [VALUE_BITS-1:0] value;
  } seq_res_t;

endpackage

`default_nettype wire

/* hdl/tdpc_rem_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "trial_division_prime_check_assert.svh"

module tdpc_rem_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tdpc_pkg::div_req_t req_i,
  output tdpc_pkg::div_rsp_t      rsp_o
);
  import tdpc_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q;
  logic [DIV_W-1:0]      dvs_q;
  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic                  ge;

  // Restoring remainder: one dividend bit per cycle, MSB first.
  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

  `TDPC_ASSERT(a_rem_below_divisor, !done_q || (rem_q < dvs_q))
  `TDPC_ASSERT_NEXT(a_start_loads_count, req_i.start, busy_q && (cnt_q == CNT_W'(VALUE_BITS)))

endmodule

`default_nettype wire

/* hdl/tdpc_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "trial_division_prime_check_assert.svh"

module tdpc_seq (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [tdpc_pkg::VALUE_BITS-1:0] candidate_i,
  output logic                                 in_stall_o,
  input  wire logic                            out_free_i,
  input  wire tdpc_pkg::div_rsp_t              div_rsp_i,
  output tdpc_pkg::div_req_t                   div_req_o,
  output tdpc_pkg::seq_res_t                   res_o
);
  import tdpc_pkg::*;

  seq_state_e            state_q, state_d;
  logic [VALUE_BITS-1:0] n_q;
  logic [DIV_W-1:0]      d_q;
  logic [SQ_W-1:0]       sq_q;
  logic                  prime_q;
  logic                  past_root;
  logic                  small_in;

  assign past_root = sq_q > {1'b0, n_q};
  assign small_in  = candidate_i < VALUE_BITS'(FIRST_DIVISOR);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = small_in ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        state_d = past_root ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp_i.done) state_d = div_rsp_i.zero ? ST_DONE : ST_CHECK;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o         = (state_q != ST_IDLE);
    div_req_o.start    = (state_q == ST_CHECK) && !past_root;
    div_req_o.dividend = n_q;
    div_req_o.divisor  = d_q;
    res_o.fin          = (state_q == ST_DONE) && out_free_i;
    res_o.prime        = prime_q;
    res_o.value        = n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_q     <= candidate_i;
          d_q     <= FIRST_DIVISOR;
          sq_q    <= FIRST_SQUARE;
          prime_q <= 1'b0;
        end
      end
      ST_CHECK: begin
        if (past_root) prime_q <= 1'b1;
      end
      ST_DIV: begin
        // Advance to the next divisor: (d+1)^2 = d^2 + 2d + 1.
        if (div_rsp_i.done && !div_rsp_i.zero) begin
          d_q  <= d_q + DIV_W'(1);
          sq_q <= sq_q + SQ_W'({d_q, 1'b1});
        end
      end
      default: begin
      end
    endcase
  end

  `TDPC_ASSERT(a_div_divisor_min, (state_q != ST_DIV) || (d_q >= FIRST_DIVISOR))
  `TDPC_ASSERT(a_prime_not_small, !(res_o.fin && res_o.prime) || (n_q >= VALUE_BITS'(FIRST_DIVISOR)))

endmodule

`default_nettype wire

/* hdl/trial_division_prime_check.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "trial_division_prime_check_assert.svh"

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    candidate_i
// out      output     out_valid_o / out_stall_i  is_prime_o, current_key_o
//
// One item at a time; 0 and 1 go straight to done, otherwise each trial divisor
// is checked against the square root and then runs one full bit-serial pass of
// the shared remainder unit, until a divisor divides or the root is passed.
// Reset clears the sequencer, the output valid and the held key (reads as 0).
// A stalled result sits in the output register; the next item is taken meanwhile
// and waits at its end until the register frees.

module trial_division_prime_check (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tdpc_pkg::VALUE_BITS-1:0] candidate_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 is_prime_o,
  output logic [tdpc_pkg::VALUE_BITS-1:0]      current_key_o
);
  import tdpc_pkg::*;

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  seq_res_t              res;
  logic                  out_free;
  logic                  out_valid_q;
  logic                  out_prime_q;
  logic [VALUE_BITS-1:0] out_key_q;
  logic [VALUE_BITS-1:0] key_q;

  assign out_free = !out_valid_q || !out_stall_i;

  tdpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .candidate_i(candidate_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .div_rsp_i  (div_rsp),
    .div_req_o  (div_req),
    .res_o      (res)
  );

  tdpc_rem_unit u_rem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      key_q       <= '0;
    end else begin
      if (res.fin) begin
        out_valid_q <= 1'b1;
        if (res.prime) key_q <= res.value;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Show the key after this item's update.
  always_ff @(posedge clk_i) begin
    if (res.fin) begin
      out_prime_q <= res.prime;
      out_key_q   <= res.prime ? res.value : key_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = out_prime_q;
  assign current_key_o = out_key_q;

  `TDPC_ASSERT(a_prime_shows_key, !(out_valid_q && out_prime_q) || (out_key_q != '0))

endmodule

`default_nettype wire

/* tb/trial_division_prime_check_tb.sv */
`timescale 1ns / 1ps

module trial_division_prime_check_tb;

  localparam int VW = tdpc_pkg::VALUE_BITS;
  localparam int unsigned CYCLE_LIMIT = 12_000_000;
  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_COUNT = 75;

  typedef struct packed {
    logic          prime;
    logic [VW-1:0] key;
  } verdict_t;

  class prime_verdict_board;
    logic [VW-1:0] held_key;
    verdict_t      pending_verdicts[$];
    int            errors;

    function new();
      held_key = '0;
      errors = 0;
    endfunction

    // Trial division with divisors from 2 while d*d <= n.
    function bit has_no_divisor(longint unsigned n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d <= n / d; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(logic [VW-1:0] candidate);
      verdict_t v;
      v.prime = has_no_divisor(longint'(candidate));
      if (v.prime) held_key = candidate;
      v.key = held_key;
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic prime, logic [VW-1:0] key);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with none pending: is_prime %0b current_key %0d",
                 $time, prime, key);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (prime !== want.prime) begin
        $display("%0t: is_prime expected %0b, actual %0b", $time, want.prime, prime);
        errors++;
      end
      if (key !== want.key) begin
        $display("%0t: current_key expected %0d, actual %0d", $time, want.key, key);
        errors++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [VW-1:0] candidate_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic          is_prime_o;
  logic [VW-1:0] current_key_o;

  prime_verdict_board board = new();

  int unsigned cycle_count = 0;
  int          stall_left = 0;
  int          quiet_left = 0;
  int          stall_roll;

  // Extremes, 0 and 1 around primes, squares of primes, composites before and
  // after the largest key.
  int unsigned directed_vals [DIRECTED_COUNT] = '{
    0, 1, 4, 9, 2, 3, 1, 0, 25, 5, 49, 7, 121, 169, 97, 65521, 65536,
    1018081, 1000003, 1073741824, 1431655765, 2147483647, 2147483646,
    715827882, 6
  };

  trial_division_prime_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .candidate_i   (candidate_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_prime_o    (is_prime_o),
    .current_key_o (current_key_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_candidate(candidate_i);
      if (out_valid_o && !out_stall_i) board.check_result(is_prime_o, current_key_o);
    end
  end

  // Receiver: mostly ready, short stalls, a few long ones, quiet stretches.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 5) begin
        quiet_left <= $urandom_range(50, 300);
        out_stall_i <= 1'b0;
      end else if (stall_roll < 25) begin
        stall_left <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else if (stall_roll < 28) begin
        stall_left <= $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Called at a clock edge; returns at the edge where the item is taken.
  task automatic send_candidate(input logic [VW-1:0] value, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  initial begin
    int unsigned roll;
    int unsigned factor;
    logic [31:0] draw;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_vals[i]) send_candidate(VW'(directed_vals[i]), pick_gap());
    drain_results();

    // Keep most draws cheap: small values, or large ones with a small factor.
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        draw = $urandom_range(0, 4095);
      end else if (roll < 55) begin
        draw = $urandom_range(4096, 1 << 20);
      end else if (roll < 75) begin
        draw = $urandom() & 32'h7FFF_FFFE;
      end else if (roll < 90) begin
        factor = 3 + 2 * $urandom_range(0, 5);
        draw = factor * $urandom_range(1, 32'h7FFF_FFFF / factor);
      end else begin
        draw = $urandom_range(0, 65535);
      end
      send_candidate(draw[VW-1:0], pick_gap());
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* trial_division_prime_check.f */
+incdir+hdl
hdl/tdpc_pkg.sv
hdl/tdpc_rem_unit.sv
hdl/tdpc_seq.sv
hdl/trial_division_prime_check.sv
tb/trial_division_prime_check_tb.sv
